// ===== rtl/mau_pkg.sv =====
// package for the modular arithmetic unit: widths, operation codes, states
`default_nettype none
package mau_pkg;
   localparam int ModWidth = 31;
   localparam int OpdWidth = 64;
   localparam logic [ModWidth-1:0] ModulusReset = 31'd1000000007;

   typedef enum logic [2:0] {
      OP_REDUCE = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_POW    = 3'd5,
      OP_INV    = 3'd6,
      OP_EQUAL  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_FIX,
      ST_INV_DIV,
      ST_INV_UPD,
      ST_INV_MUL,
      ST_MUL,
      ST_POW_STEP,
      ST_POW_SQ,
      ST_FINISH,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/mau_if.sv =====
// valid/ready channel interfaces for requests and results
`default_nettype none
interface mau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic signed [63:0] operand_a;
   logic signed [63:0] operand_b;
   modport source (output valid, req_type, operand_a, operand_b, input ready);
   modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface mau_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] result;
   logic        is_equal;
   logic        error;
   modport source (output valid, result, is_equal, error, input ready);
   modport sink (input valid, result, is_equal, error, output ready);
endinterface
`default_nettype wire

// ===== rtl/modular_arithmetic_unit.sv =====
// modular arithmetic unit: one shared restoring remainder unit under a sequencer
// reduction runs bit-serially over each 64-bit operand and each multiply reduces
// its product through the same unit; a power does up to 63 squarings and multiplies,
// an inverse runs euclid steps each a 32-bit bit-serial division; one request at a time
// throughput is set by the single bit-serial divide/remainder unit
// reset (synchronous) returns the modulus to 1000000007 and the sequencer to idle
`default_nettype none
module modular_arithmetic_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_we,
   input wire logic [30:0] csr_wdata,
   mau_req_if.sink req,
   mau_rsp_if.source rsp
);
   localparam int MW = mau_pkg::ModWidth;

   logic [MW-1:0] mod_ff;
   mau_pkg::state_type state_ff, state_in;
   mau_pkg::op_type op_ff;
   logic [63:0] opa_ff, opb_ff, exp_ff;
   logic [MW-1:0] a_ff, b_ff, res_ff, base_ff;
   logic eq_ff, err_ff;
   // shared divider: dividend shifts out msb-first, remainder accumulates
   logic [63:0] dvd_ff, quo_ff;
   logic [MW:0] rem_ff;
   logic [6:0] cnt_ff;
   logic neg_ff;
   // euclid registers
   logic [MW:0] ex_ff, ey_ff;
   logic signed [33:0] eu_ff, ev_ff;
   logic pow_mul_ff;

   logic [MW-1:0] m_eff;
   assign m_eff = (mod_ff < 31'd2) ? 31'd1 : mod_ff;

   // one remainder step
   logic [MW+1:0] trial;
   logic [MW:0] rem_next;
   logic qbit;
   always_comb begin
      trial = {rem_ff, dvd_ff[63]};
      qbit = trial >= {2'b0, m_eff};
      rem_next = qbit ? (MW+1)'(trial - {2'b0, m_eff}) : trial[MW:0];
   end
   // euclid divider uses ey as divisor
   logic [MW+1:0] etrial;
   logic [MW:0] erem_next;
   logic eqbit;
   always_comb begin
      etrial = {rem_ff, dvd_ff[63]};
      eqbit = etrial >= {1'b0, ey_ff};
      erem_next = eqbit ? (MW+1)'(etrial - {1'b0, ey_ff}) : etrial[MW:0];
   end

   logic [MW-1:0] fix_val;
   logic [61:0] prod;
   assign prod = 62'(a_ff) * 62'(b_ff);

   // modulus register
   always_ff @(posedge clock) begin
      if (reset) mod_ff <= mau_pkg::ModulusReset;
      else if (csr_we) mod_ff <= csr_wdata;
   end

   assign req.ready = (state_ff == mau_pkg::ST_IDLE);
   assign rsp.valid = (state_ff == mau_pkg::ST_OUT);
   assign rsp.result = res_ff;
   assign rsp.is_equal = eq_ff;
   assign rsp.error = err_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mau_pkg::ST_IDLE: if (req.valid) state_in = mau_pkg::ST_RED_A;
         mau_pkg::ST_OUT: if (rsp.ready) state_in = mau_pkg::ST_IDLE;
         default: state_in = state_ff;
      endcase
   end

   // fold remainder back to a non-negative residue
   assign fix_val = (neg_ff && rem_ff != '0) ? MW'(m_eff - rem_ff[MW-1:0])
                                              : rem_ff[MW-1:0];

   // sequencer and datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mau_pkg::ST_IDLE;
      end else begin
         case (state_ff)
            mau_pkg::ST_IDLE: begin
               if (req.valid) begin
                  op_ff <= mau_pkg::op_type'(req.req_type);
                  opa_ff <= req.operand_a;
                  opb_ff <= req.operand_b;
                  exp_ff <= req.operand_b;
                  neg_ff <= req.operand_a[63];
                  dvd_ff <= req.operand_a[63] ? 64'(-req.operand_a) : req.operand_a;
                  rem_ff <= '0;
                  cnt_ff <= '0;
                  eq_ff <= 1'b0;
                  err_ff <= 1'b0;
                  res_ff <= '0;
                  state_ff <= mau_pkg::ST_RED_A;
               end
            end
            mau_pkg::ST_RED_A, mau_pkg::ST_RED_B, mau_pkg::ST_MUL: begin
               rem_ff <= rem_next;
               dvd_ff <= {dvd_ff[62:0], 1'b0};
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd63) state_ff <= mau_pkg::ST_FIX;
               else if (state_ff != mau_pkg::ST_MUL || 1'b1) state_ff <= state_ff;
               if (cnt_ff == 7'd63) op_ff <= op_ff;
               if (cnt_ff == 7'd63) pow_mul_ff <= pow_mul_ff;
               if (cnt_ff == 7'd63) base_ff <= base_ff;
               if (cnt_ff == 7'd63) cnt_ff <= {1'b0, state_ff == mau_pkg::ST_RED_A,
                                               state_ff == mau_pkg::ST_RED_B,
                                               state_ff == mau_pkg::ST_MUL, 3'b0};
            end
            mau_pkg::ST_FIX: begin
               // cnt_ff carries which phase finished
               rem_ff <= '0;
               if (cnt_ff[5]) begin
                  a_ff <= fix_val;
                  neg_ff <= opb_ff[63];
                  dvd_ff <= opb_ff[63] ? 64'(-opb_ff) : opb_ff;
                  cnt_ff <= '0;
                  state_ff <= mau_pkg::ST_RED_B;
               end else if (cnt_ff[4]) begin
                  b_ff <= fix_val;
                  neg_ff <= 1'b0;
                  case (op_ff)
                     mau_pkg::OP_REDUCE: begin
                        res_ff <= a_ff; state_ff <= mau_pkg::ST_OUT;
                     end
                     mau_pkg::OP_ADD: begin
                        res_ff <= (32'(a_ff) + 32'(fix_val) >= 32'(m_eff))
                           ? MW'(32'(a_ff) + 32'(fix_val) - 32'(m_eff))
                           : MW'(32'(a_ff) + 32'(fix_val));
                        state_ff <= mau_pkg::ST_OUT;
                     end
                     mau_pkg::OP_SUB: begin
                        res_ff <= (a_ff >= fix_val) ? MW'(a_ff - fix_val)
                                                    : MW'(a_ff + m_eff - fix_val);
                        state_ff <= mau_pkg::ST_OUT;
                     end
                     mau_pkg::OP_MUL: begin
                        dvd_ff <= 64'(prod_ab(a_ff, fix_val));
                        cnt_ff <= '0; pow_mul_ff <= 1'b0;
                        state_ff <= mau_pkg::ST_MUL;
                     end
                     mau_pkg::OP_DIV: begin
                        ex_ff <= {1'b0, fix_val}; ey_ff <= {1'b0, m_eff};
                        eu_ff <= 34'sd1; ev_ff <= '0;
                        state_ff <= mau_pkg::ST_INV_DIV;
                        cnt_ff <= '0;
                     end
                     mau_pkg::OP_POW: begin
                        if (exp_ff[63]) begin
                           err_ff <= 1'b1; state_ff <= mau_pkg::ST_OUT;
                        end else begin
                           base_ff <= a_ff;
                           res_ff <= (m_eff == 31'd1) ? '0 : 31'd1;
                           state_ff <= mau_pkg::ST_POW_STEP;
                        end
                     end
                     mau_pkg::OP_INV: begin
                        ex_ff <= {1'b0, a_ff}; ey_ff <= {1'b0, m_eff};
                        eu_ff <= 34'sd1; ev_ff <= '0;
                        state_ff <= mau_pkg::ST_INV_DIV;
                        cnt_ff <= '0;
                     end
                     default: begin
                        eq_ff <= (a_ff == fix_val); state_ff <= mau_pkg::ST_OUT;
                     end
                  endcase
               end else begin
                  // product remainder done
                  case (op_ff)
                     mau_pkg::OP_POW: begin
                        if (pow_mul_ff) begin
                           res_ff <= rem_ff[MW-1:0];
                           dvd_ff <= 64'(prod_ab(base_ff, base_ff));
                           pow_mul_ff <= 1'b0; cnt_ff <= '0;
                           state_ff <= mau_pkg::ST_MUL;
                        end else begin
                           base_ff <= rem_ff[MW-1:0];
                           exp_ff <= {1'b0, exp_ff[63:1]};
                           state_ff <= mau_pkg::ST_POW_STEP;
                        end
                     end
                     default: begin
                        res_ff <= rem_ff[MW-1:0]; state_ff <= mau_pkg::ST_OUT;
                     end
                  endcase
               end
            end
            mau_pkg::ST_POW_STEP: begin
               rem_ff <= '0; cnt_ff <= '0;
               if (exp_ff == '0) state_ff <= mau_pkg::ST_OUT;
               else if (exp_ff[0]) begin
                  dvd_ff <= 64'(prod_ab(res_ff, base_ff));
                  pow_mul_ff <= 1'b1; state_ff <= mau_pkg::ST_MUL;
               end else begin
                  dvd_ff <= 64'(prod_ab(base_ff, base_ff));
                  pow_mul_ff <= 1'b0; state_ff <= mau_pkg::ST_MUL;
               end
            end
            mau_pkg::ST_INV_DIV: begin
               // bit-serial quotient ex / ey over 32 bits
               if (cnt_ff == 7'd0) begin
                  if (ey_ff == '0) state_ff <= mau_pkg::ST_FINISH;
                  else begin
                     dvd_ff <= {ex_ff, 32'b0}; rem_ff <= '0; quo_ff <= '0;
                     cnt_ff <= 7'd1;
                  end
               end else begin
                  rem_ff <= erem_next;
                  dvd_ff <= {dvd_ff[62:0], 1'b0};
                  quo_ff <= {quo_ff[62:0], eqbit};
                  cnt_ff <= cnt_ff + 7'd1;
                  if (cnt_ff == 7'd32) state_ff <= mau_pkg::ST_INV_UPD;
               end
            end
            mau_pkg::ST_INV_UPD: begin
               ex_ff <= ey_ff; ey_ff <= rem_ff;
               dvd_ff <= 64'(signed'(eu_ff) - signed'(34'(quo_ff[31:0])) * ev_ff);
               state_ff <= mau_pkg::ST_INV_MUL;
            end
            mau_pkg::ST_INV_MUL: begin
               eu_ff <= ev_ff; ev_ff <= 34'(dvd_ff);
               cnt_ff <= '0; state_ff <= mau_pkg::ST_INV_DIV;
            end
            mau_pkg::ST_FINISH: begin
               // reduce coefficient u and either return or multiply
               neg_ff <= eu_ff[33];
               dvd_ff <= eu_ff[33] ? 64'(-eu_ff) : 64'(eu_ff);
               rem_ff <= '0; cnt_ff <= '0;
               op_ff <= (op_ff == mau_pkg::OP_DIV) ? mau_pkg::OP_DIV : mau_pkg::OP_INV;
               state_ff <= mau_pkg::ST_RED_B;
               b_ff <= b_ff;
               opb_ff <= opb_ff;
               // reuse red_b then finish in fix with op inv or div
               a_ff <= a_ff;
               pow_mul_ff <= 1'b1;
            end
            mau_pkg::ST_OUT: if (rsp.ready) state_ff <= mau_pkg::ST_IDLE;
            default: state_ff <= mau_pkg::ST_IDLE;
         endcase
         // after euclid reduction, fix routes through red_b with pow_mul flag
         if (state_ff == mau_pkg::ST_FIX && cnt_ff[4] && pow_mul_ff &&
             (op_ff == mau_pkg::OP_INV || op_ff == mau_pkg::OP_DIV) && euclid_done_ff) begin
            if (op_ff == mau_pkg::OP_INV) begin
               res_ff <= fix_val; state_ff <= mau_pkg::ST_OUT;
            end else begin
               dvd_ff <= 64'(prod_ab(a_ff, fix_val)); rem_ff <= '0; cnt_ff <= '0;
               op_ff <= mau_pkg::OP_MUL; state_ff <= mau_pkg::ST_MUL;
            end
         end
      end
   end

   // marks that the reduction in progress is of the euclid coefficient
   logic euclid_done_ff;
   always_ff @(posedge clock) begin
      if (reset) euclid_done_ff <= 1'b0;
      else if (state_ff == mau_pkg::ST_FINISH) euclid_done_ff <= 1'b1;
      else if (state_ff == mau_pkg::ST_IDLE) euclid_done_ff <= 1'b0;
   end

   function automatic logic [61:0] prod_ab(input logic [MW-1:0] x, input logic [MW-1:0] y);
      prod_ab = 62'(x) * 62'(y);
   endfunction

   logic unused_ok;
   assign unused_ok = ^{prod, state_in};

   // checks on the sequencer
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while result pending");
   a_res_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.result < m_eff || m_eff == 31'd1)) else $error("result out of range");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.error) |-> rsp.result == '0) else $error("error with nonzero result");
endmodule
`default_nettype wire
